// File: rtl/kleb_pkg.sv
`default_nettype none

package kleb_pkg;

    localparam int BufSize = 256;
    localparam int AddrW   = $clog2(BufSize);
    localparam int LenW    = AddrW + 1;

    localparam logic [7:0] KeyHome      = 8'h01;
    localparam logic [7:0] KeyEnter     = 8'h03;
    localparam logic [7:0] KeyEnd       = 8'h04;
    localparam logic [7:0] KeyBackspace = 8'h08;
    localparam logic [7:0] KeyTab       = 8'h09;
    localparam logic [7:0] KeyPageUp    = 8'h0B;
    localparam logic [7:0] KeyPageDown  = 8'h0C;
    localparam logic [7:0] KeyReturn    = 8'h0D;
    localparam logic [7:0] KeyLeft      = 8'h1C;
    localparam logic [7:0] KeyRight     = 8'h1D;
    localparam logic [7:0] KeyUp        = 8'h1E;
    localparam logic [7:0] KeyDown      = 8'h1F;
    localparam logic [7:0] KeySpace     = 8'h20;
    localparam logic [7:0] KeyDelete    = 8'h7F;
    localparam logic [7:0] KeyLowerA    = 8'h61;
    localparam logic [7:0] KeyLowerZ    = 8'h7A;
    localparam logic [7:0] KeyUpperC    = 8'h43;
    localparam logic [7:0] KeyUpperX    = 8'h58;
    localparam logic [7:0] KeyUpperV    = 8'h56;
    localparam logic [7:0] CaseFold     = 8'd32;

    typedef enum logic [1:0] {
        FN_KEY  = 2'd0,
        FN_SET  = 2'd1,
        FN_READ = 2'd2,
        FN_NOP  = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        KC_IGNORED = 3'd0,
        KC_PRINT   = 3'd1,
        KC_NAV     = 3'd2,
        KC_DELETE  = 3'd3,
        KC_CLIP    = 3'd4
    } t_kclass;

    typedef enum logic [1:0] {
        CLIP_NONE  = 2'd0,
        CLIP_COPY  = 2'd1,
        CLIP_CUT   = 2'd2,
        CLIP_PASTE = 2'd3
    } t_clip;

    typedef struct packed {
        t_kclass kclass;
        t_clip   clip;
    } t_key_info;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_INS_SHIFT,
        S_INS_PUT,
        S_DEL_SHIFT,
        S_DEL_END,
        S_READ,
        S_DONE
    } t_state;

    typedef struct packed {
        logic latch;
        logic decode;
        logic ins_step;
        logic ins_put;
        logic del_step;
        logic del_end;
        logic read_cap;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic do_ins;
        logic do_del;
        logic do_read;
        logic ins_done;
        logic del_done;
    } t_dp_status;

    function automatic logic is_nav_key(input logic [7:0] code);
        return code == KeyLeft || code == KeyRight || code == KeyUp || code == KeyDown ||
               code == KeyHome || code == KeyEnd || code == KeyPageUp ||
               code == KeyPageDown;
    endfunction

    function automatic t_key_info kleb_classify(input logic [7:0] code, input logic cmd,
                                                input logic clr);
        t_key_info  info;
        logic [7:0] up;
        info.kclass = KC_IGNORED;
        info.clip   = CLIP_NONE;
        up = code;
        if (code >= KeyLowerA && code <= KeyLowerZ) begin
            up = code - CaseFold;
        end
        if (cmd) begin
            if (up == KeyUpperC) begin
                info.clip = CLIP_COPY;
            end else if (up == KeyUpperX) begin
                info.clip = CLIP_CUT;
            end else if (up == KeyUpperV) begin
                info.clip = CLIP_PASTE;
            end
            info.kclass = (info.clip != CLIP_NONE) ? KC_CLIP : KC_IGNORED;
        end else if ((code >= KeySpace && code != KeyDelete) || code == KeyReturn ||
                     code == KeyEnter || code == KeyTab) begin
            info.kclass = KC_PRINT;
        end else if (is_nav_key(code)) begin
            info.kclass = KC_NAV;
        end else if (code == KeyDelete || code == KeyBackspace || clr) begin
            info.kclass = KC_DELETE;
        end
        return info;
    endfunction

endpackage

`default_nettype wire

// File: rtl/kleb_if.sv
`default_nettype none

interface kleb_in_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                func;
    logic [7:0]                key_code;
    logic                      command_held;
    logic                      clear_key;
    logic [kleb_pkg::LenW-1:0] position;

    modport source (output valid, func, key_code, command_held, clear_key, position,
                    input ready);
    modport sink (input valid, func, key_code, command_held, clear_key, position,
                  output ready);
endinterface

interface kleb_out_if;
    logic                      valid;
    logic                      ready;
    logic [kleb_pkg::LenW-1:0] cursor;
    logic [kleb_pkg::LenW-1:0] text_length;
    logic [2:0]                key_class;
    logic [1:0]                clip_action;
    logic [7:0]                read_char;
    logic                      overflow;

    modport source (output valid, cursor, text_length, key_class, clip_action, read_char,
                    overflow, input ready);
    modport sink (input valid, cursor, text_length, key_class, clip_action, read_char,
                  overflow, output ready);
endinterface

`default_nettype wire

// File: rtl/kleb_ram.sv
`default_nettype none

module kleb_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/kleb_ctrl.sv
`default_nettype none

module kleb_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    input  wire kleb_pkg::t_dp_status i_status,
    output kleb_pkg::t_dp_cmd         o_cmd
);
    import kleb_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid & ~i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                priority if (i_status.do_ins) begin
                    n_state = S_INS_SHIFT;
                end else if (i_status.do_del) begin
                    n_state = S_DEL_SHIFT;
                end else if (i_status.do_read) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_INS_SHIFT: begin
                o_cmd.ins_step = 1'b1;
                if (i_status.ins_done) begin
                    n_state = S_INS_PUT;
                end
            end
            S_INS_PUT: begin
                o_cmd.ins_put = 1'b1;
                n_state       = S_DONE;
            end
            S_DEL_SHIFT: begin
                o_cmd.del_step = 1'b1;
                if (i_status.del_done) begin
                    n_state = S_DEL_END;
                end
            end
            S_DEL_END: begin
                o_cmd.del_end = 1'b1;
                n_state       = S_DONE;
            end
            S_READ: begin
                o_cmd.read_cap = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                // output register free, or being emptied this cycle
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

    a_accept_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> r_state == S_DECODE)
        else $error("accepted beat did not move to decode");

    a_load_no_clobber: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten while still held");

endmodule

`default_nettype wire

// File: rtl/kleb_dp.sv
`default_nettype none

module kleb_dp (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire kleb_pkg::t_dp_cmd         i_cmd,
    output kleb_pkg::t_dp_status           o_status,
    input  wire logic [1:0]                i_func,
    input  wire logic [7:0]                i_key_code,
    input  wire logic                      i_command_held,
    input  wire logic                      i_clear_key,
    input  wire logic [kleb_pkg::LenW-1:0] i_position,
    output logic      [kleb_pkg::LenW-1:0] o_cursor,
    output logic      [kleb_pkg::LenW-1:0] o_text_length,
    output logic      [2:0]                o_key_class,
    output logic      [1:0]                o_clip_action,
    output logic      [7:0]                o_read_char,
    output logic                           o_overflow
);
    import kleb_pkg::*;

    localparam logic [LenW-1:0] Full = LenW'(BufSize);

    // latched item
    t_func            r_func;
    logic [7:0]       r_code;
    logic             r_cmd;
    logic             r_clr;
    logic [LenW-1:0]  r_pos;

    logic [LenW-1:0]  r_len,   n_len;
    logic [LenW-1:0]  r_cur,   n_cur;
    logic [LenW-1:0]  r_idx,   n_idx;
    logic             r_wp,    n_wp;
    logic [AddrW-1:0] r_wa,    n_wa;
    logic             r_ovf,   n_ovf;
    logic [7:0]       r_rchar, n_rchar;

    logic [LenW-1:0]  idx_dn;
    logic [LenW-1:0]  idx_up;
    t_key_info        info;
    logic             is_key;

    logic             ram_we;
    logic [AddrW-1:0] ram_waddr;
    logic [7:0]       ram_wdata;
    logic [AddrW-1:0] ram_raddr;
    logic [7:0]       ram_rdata;

    assign idx_dn = r_idx - 1'b1;
    assign idx_up = r_idx + 1'b1;
    assign info   = kleb_classify(r_code, r_cmd, r_clr);
    assign is_key = (r_func == FN_KEY);

    assign o_status.do_ins   = is_key && info.kclass == KC_PRINT && r_len != Full;
    assign o_status.do_del   = is_key && info.kclass == KC_DELETE &&
                               ((r_code == KeyBackspace && r_cur != '0) ||
                                (r_code == KeyDelete && r_cur < r_len));
    assign o_status.do_read  = (r_func == FN_READ) && r_pos < r_len;
    assign o_status.ins_done = (r_idx == r_cur);
    assign o_status.del_done = (idx_up >= r_len);

    // shift moves one character a cycle: read ahead, write the previous read back
    always_comb begin
        ram_raddr = r_pos[AddrW-1:0];
        if (i_cmd.ins_step) begin
            ram_raddr = idx_dn[AddrW-1:0];
        end else if (i_cmd.del_step) begin
            ram_raddr = idx_up[AddrW-1:0];
        end
        ram_we    = r_wp | i_cmd.ins_put;
        ram_waddr = i_cmd.ins_put ? r_cur[AddrW-1:0] : r_wa;
        ram_wdata = i_cmd.ins_put ? r_code : ram_rdata;
    end

    kleb_ram #(
        .Width (8),
        .Depth (BufSize)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_len   = r_len;
        n_cur   = r_cur;
        n_idx   = r_idx;
        n_wp    = 1'b0;
        n_wa    = r_wa;
        n_ovf   = r_ovf;
        n_rchar = r_rchar;
        if (i_cmd.decode) begin
            n_ovf   = 1'b0;
            n_rchar = '0;
            unique case (r_func)
                FN_KEY: begin
                    unique case (info.kclass)
                        KC_PRINT: begin
                            if (r_len == Full) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_idx = r_len;
                            end
                        end
                        KC_NAV: begin
                            if (r_code == KeyUp || r_code == KeyHome) begin
                                n_cur = '0;
                            end else if (r_code == KeyDown || r_code == KeyEnd) begin
                                n_cur = r_len;
                            end else if (r_code == KeyLeft) begin
                                if (r_cur != '0) begin
                                    n_cur = r_cur - 1'b1;
                                end
                            end else if (r_code == KeyRight) begin
                                if (r_cur < r_len) begin
                                    n_cur = r_cur + 1'b1;
                                end
                            end
                        end
                        KC_DELETE: begin
                            if (r_code == KeyBackspace) begin
                                if (r_cur != '0) begin
                                    n_idx = r_cur - 1'b1;
                                    n_cur = r_cur - 1'b1;
                                end
                            end else if (r_code == KeyDelete) begin
                                n_idx = r_cur;
                            end else begin
                                n_len = '0;
                                n_cur = '0;
                            end
                        end
                        default: ;
                    endcase
                end
                FN_SET:  n_cur = (r_pos > r_len) ? r_len : r_pos;
                FN_READ: ;
                FN_NOP:  ;
                default: ;
            endcase
        end
        if (i_cmd.ins_step && r_idx != r_cur) begin
            n_wp  = 1'b1;
            n_wa  = r_idx[AddrW-1:0];
            n_idx = idx_dn;
        end
        if (i_cmd.ins_put) begin
            n_len = r_len + 1'b1;
            n_cur = r_cur + 1'b1;
        end
        if (i_cmd.del_step && !o_status.del_done) begin
            n_wp  = 1'b1;
            n_wa  = r_idx[AddrW-1:0];
            n_idx = idx_up;
        end
        if (i_cmd.del_end) begin
            n_len = r_len - 1'b1;
        end
        if (i_cmd.read_cap) begin
            n_rchar = ram_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_cur <= '0;
            r_wp  <= 1'b0;
        end else begin
            r_len <= n_len;
            r_cur <= n_cur;
            r_wp  <= n_wp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_wa    <= n_wa;
        r_ovf   <= n_ovf;
        r_rchar <= n_rchar;
        if (i_cmd.latch) begin
            r_func <= t_func'(i_func);
            r_code <= i_key_code;
            r_cmd  <= i_command_held;
            r_clr  <= i_clear_key;
            r_pos  <= i_position;
        end
        if (i_cmd.load_out) begin
            o_cursor      <= r_cur;
            o_text_length <= r_len;
            o_key_class   <= is_key ? info.kclass : KC_IGNORED;
            o_clip_action <= is_key ? info.clip : CLIP_NONE;
            o_read_char   <= r_rchar;
            o_overflow    <= r_ovf;
        end
    end

    a_cursor_in_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur <= r_len)
        else $error("cursor beyond text length");

    a_len_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= Full)
        else $error("text length beyond store size");

    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_wp && i_cmd.ins_put))
        else $error("shift write collides with character insert");

    a_ins_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins_put |-> r_len != Full)
        else $error("insert into a full store");

endmodule

`default_nettype wire

// File: rtl/keystroke_line_edit_buffer.sv
// Operation: each input beat is latched and decoded; an insert first shifts the
//   characters from the cursor to the end up by one, a delete shifts those after
//   the index down by one, and a character read captures one store entry.
// Throughput: one item at a time; the shift through the store moves
//   one character a cycle. A new beat is taken while the last result waits.
// Reset: synchronous, active low; clears length, cursor and handshake state.
//   The character store is not cleared; entries past the length are never returned.
`default_nettype none

module keystroke_line_edit_buffer (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    kleb_in_if.sink   i_in,
    kleb_out_if.source o_out
);
    import kleb_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    kleb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    kleb_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_func         (i_in.func),
        .i_key_code     (i_in.key_code),
        .i_command_held (i_in.command_held),
        .i_clear_key    (i_in.clear_key),
        .i_position     (i_in.position),
        .o_cursor       (o_out.cursor),
        .o_text_length  (o_out.text_length),
        .o_key_class    (o_out.key_class),
        .o_clip_action  (o_out.clip_action),
        .o_read_char    (o_out.read_char),
        .o_overflow     (o_out.overflow)
    );

endmodule

`default_nettype wire
